// ===== sv/plc_pkg.sv =====
// Shared types, constants and the half-step table for the proximity lid stepper controller.
package plc_pkg;

    // Field widths fixed by the interface.
    localparam int ECHO_W   = 24;
    localparam int CYCLE_W  = 10;
    localparam int TICK_W   = 8;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_MEASURE = 2'd1,
        OP_BUTTON  = 2'd2
    } plc_op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_COUNT         = 3'd0,
        REG_MANUAL_CLOSE_COUNT = 3'd1,
        REG_VALID_LIMIT_COUNT  = 3'd2,
        REG_OPEN_CYCLES        = 3'd3,
        REG_CLOSE_CYCLES       = 3'd4,
        REG_STEP_TICKS         = 3'd5
    } plc_reg_t;

    // Register reset values (15 cm, 23 cm and 1000 cm as echo counts).
    localparam logic [ECHO_W-1:0]  NEAR_COUNT_RST         = 24'd874;
    localparam logic [ECHO_W-1:0]  MANUAL_CLOSE_COUNT_RST = 24'd1341;
    localparam logic [ECHO_W-1:0]  VALID_LIMIT_COUNT_RST  = 24'd58308;
    localparam logic [CYCLE_W-1:0] OPEN_CYCLES_RST        = 10'd120;
    localparam logic [CYCLE_W-1:0] CLOSE_CYCLES_RST       = 10'd140;
    localparam logic [TICK_W-1:0]  STEP_TICKS_RST         = 8'd10;

    // Half-step coil sequence in the opening direction.
    localparam logic [3:0] HALF_STEP [8] = '{
        4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8
    };

    // One input beat.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] capture_value;
        logic [7:0]  overflow_count;
    } plc_in_t;

    // One result beat.
    typedef struct packed {
        logic [3:0]        coil_pattern;
        logic              lid_open;
        logic              manual_mode;
        logic              moving;
        logic              move_done;
        logic [ECHO_W-1:0] echo_count;
    } plc_out_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [ECHO_W-1:0]  near_count;
        logic [ECHO_W-1:0]  manual_close_count;
        logic [ECHO_W-1:0]  valid_limit_count;
        logic [CYCLE_W-1:0] open_cycles;
        logic [CYCLE_W-1:0] close_cycles;
        logic [TICK_W-1:0]  step_ticks;
    } plc_cfg_t;

    // Coil pattern for a phase; reverse runs the table backward.
    function automatic logic [3:0] half_step(input logic [2:0] phase, input logic rev);
        logic [2:0] idx;
        idx = rev ? 3'(3'd7 - phase) : phase;
        return HALF_STEP[idx];
    endfunction

endpackage

// ===== sv/plc_core.sv =====
// Lid state, motion sequencer and echo decision logic, updated once per beat.
module plc_core
    import plc_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step_en,
    input  plc_in_t  item,
    input  plc_cfg_t cfg,
    output plc_out_t result
);

    // Echo counts saturate at the narrower of COUNT_BITS and the field width.
    localparam int SAT_BITS = (COUNT_BITS < ECHO_W) ? COUNT_BITS : ECHO_W;
    localparam logic [ECHO_W-1:0] SAT_MAX = ECHO_W'((64'd1 << SAT_BITS) - 64'd1);

    logic               open_reg, open_next;
    logic               manual_reg, manual_next;
    logic               run_reg, run_next;
    logic               reverse_reg, reverse_next;
    logic               clr_manual_reg, clr_manual_next;
    logic [CYCLE_W-1:0] cycles_left_reg, cycles_left_next;
    logic [2:0]         phase_reg, phase_next;
    logic [TICK_W-1:0]  hold_reg, hold_next;
    logic [3:0]         drive_reg, drive_next;
    logic [ECHO_W-1:0]  last_count_reg, last_count_next;

    logic [ECHO_W-1:0]  raw_count;
    logic [ECHO_W-1:0]  echo_cnt;
    logic [TICK_W-1:0]  hold_inc;
    logic [2:0]         phase_inc;
    logic [CYCLE_W-1:0] cycles_dec;
    logic               start;
    logic               opening;
    logic               clr_eff;
    logic [CYCLE_W-1:0] start_cycles;
    logic               done;

    // Join capture and overflow count, then saturate.
    assign raw_count = {item.overflow_count, item.capture_value};
    assign echo_cnt  = (raw_count > SAT_MAX) ? SAT_MAX : raw_count;

    assign hold_inc     = hold_reg + 8'd1;
    assign phase_inc    = phase_reg + 3'd1;
    assign cycles_dec   = cycles_left_reg - 10'd1;
    assign start_cycles = opening ? cfg.open_cycles : cfg.close_cycles;

    // Next-state logic for one beat.
    always_comb
    begin
        open_next        = open_reg;
        manual_next      = manual_reg;
        run_next         = run_reg;
        reverse_next     = reverse_reg;
        clr_manual_next  = clr_manual_reg;
        cycles_left_next = cycles_left_reg;
        phase_next       = phase_reg;
        hold_next        = hold_reg;
        drive_next       = drive_reg;
        last_count_next  = last_count_reg;
        done             = 1'b0;
        start            = 1'b0;
        opening          = 1'b0;
        clr_eff          = clr_manual_reg;

        case (item.opcode)
            OP_TICK:
            begin
                // Advance the hold counter and step the coils when it expires.
                if (run_reg)
                begin
                    hold_next = hold_inc;
                    if (hold_inc >= cfg.step_ticks)
                    begin
                        hold_next  = '0;
                        phase_next = phase_inc;
                        if (phase_inc == 3'd0)
                        begin
                            cycles_left_next = cycles_dec;
                            if (cycles_dec == '0)
                            begin
                                run_next        = 1'b0;
                                done            = 1'b1;
                                clr_manual_next = 1'b0;
                                if (clr_manual_reg)
                                begin
                                    manual_next = 1'b0;
                                end
                            end
                        end
                        if (!(phase_inc == 3'd0 && cycles_dec == '0))
                        begin
                            drive_next = half_step(phase_inc, reverse_reg);
                        end
                    end
                end
            end
            OP_MEASURE:
            begin
                // Measurements only count while the motor is idle.
                if (!run_reg)
                begin
                    last_count_next = echo_cnt;
                    if (echo_cnt <= cfg.valid_limit_count)
                    begin
                        if (!manual_reg)
                        begin
                            if (!open_reg && echo_cnt <= cfg.near_count)
                            begin
                                start   = 1'b1;
                                opening = 1'b1;
                            end
                            else if (open_reg && echo_cnt > cfg.near_count)
                            begin
                                start = 1'b1;
                            end
                        end
                        else
                        begin
                            if (open_reg && echo_cnt <= cfg.manual_close_count)
                            begin
                                start   = 1'b1;
                                clr_eff = 1'b1;
                            end
                            else if (!open_reg)
                            begin
                                start   = 1'b1;
                                opening = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_BUTTON:
            begin
                manual_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Motion start; a zero cycle count finishes at once without moving.
        if (start)
        begin
            open_next    = opening;
            reverse_next = !opening;
            if (start_cycles == '0)
            begin
                done            = 1'b1;
                clr_manual_next = 1'b0;
                if (clr_eff)
                begin
                    manual_next = 1'b0;
                end
            end
            else
            begin
                clr_manual_next  = clr_eff;
                run_next         = 1'b1;
                cycles_left_next = start_cycles;
                phase_next       = '0;
                hold_next        = '0;
                drive_next       = half_step(3'd0, !opening);
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg        <= 1'b0;
            manual_reg      <= 1'b0;
            run_reg         <= 1'b0;
            reverse_reg     <= 1'b0;
            clr_manual_reg  <= 1'b0;
            cycles_left_reg <= '0;
            phase_reg       <= '0;
            hold_reg        <= '0;
            drive_reg       <= '0;
            last_count_reg  <= '0;
        end
        else if (step_en)
        begin
            open_reg        <= open_next;
            manual_reg      <= manual_next;
            run_reg         <= run_next;
            reverse_reg     <= reverse_next;
            clr_manual_reg  <= clr_manual_next;
            cycles_left_reg <= cycles_left_next;
            phase_reg       <= phase_next;
            hold_reg        <= hold_next;
            drive_reg       <= drive_next;
            last_count_reg  <= last_count_next;
        end
    end

    // Result reflects the state after this beat.
    always_comb
    begin
        result.coil_pattern = drive_next;
        result.lid_open     = open_next;
        result.manual_mode  = manual_next;
        result.moving       = run_next;
        result.move_done    = done;
        result.echo_count   = last_count_next;
    end

endmodule

// ===== sv/proximity_lid_stepper_controller.sv =====
// Top level: configuration registers, input register, core and result register.
// A beat in the input register steps the core; its status is then registered and
// offered as a result. One beat per cycle with no gaps while results are not
// stalled; in a stall the input register can take one beat, then stalls.
// Reset (rst_n low, asynchronous): lid closed, automatic mode, coils off,
// echo count zero, registers at their default thresholds, pipeline empty.
module proximity_lid_stepper_controller
    import plc_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  plc_in_t              item_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output plc_out_t             result_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    plc_cfg_t cfg_reg;
    plc_in_t  item_reg;
    logic     item_valid_reg;
    plc_out_t result_reg;
    logic     result_valid_reg;
    plc_out_t core_result;
    logic     result_free;
    logic     step_en;

    // Handshake: the result slot frees when empty or being taken.
    assign result_free = !result_valid_reg || !result_stall;
    assign step_en     = item_valid_reg && result_free;
    assign item_stall  = item_valid_reg && !result_free;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_count         <= NEAR_COUNT_RST;
            cfg_reg.manual_close_count <= MANUAL_CLOSE_COUNT_RST;
            cfg_reg.valid_limit_count  <= VALID_LIMIT_COUNT_RST;
            cfg_reg.open_cycles        <= OPEN_CYCLES_RST;
            cfg_reg.close_cycles       <= CLOSE_CYCLES_RST;
            cfg_reg.step_ticks         <= STEP_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NEAR_COUNT:         cfg_reg.near_count         <= cfg_data;
                REG_MANUAL_CLOSE_COUNT: cfg_reg.manual_close_count <= cfg_data;
                REG_VALID_LIMIT_COUNT:  cfg_reg.valid_limit_count  <= cfg_data;
                REG_OPEN_CYCLES:        cfg_reg.open_cycles  <= cfg_data[CYCLE_W-1:0];
                REG_CLOSE_CYCLES:       cfg_reg.close_cycles <= cfg_data[CYCLE_W-1:0];
                REG_STEP_TICKS:         cfg_reg.step_ticks   <= cfg_data[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item_data;
        end
    end

    plc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_free)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the proximity lid stepper controller.
module tb;
    import plc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Opcode value with no defined meaning; the block must ignore it.
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [ECHO_W:0] ECHO_MAX = (25'd1 << ECHO_W) - 25'd1;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int PHASE_BEATS = 85;

    // Half-step coil sequence, opening direction.
    localparam logic [3:0] COIL_SEQ [8] = '{
        4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_stall;
    plc_in_t  item_data = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    plc_out_t result_data;
    logic     cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NEAR_COUNT;
    logic [CFG_W-1:0]     cfg_data = '0;

    proximity_lid_stepper_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Predicted registers and controller state.
    plc_cfg_t    cfg_m;
    logic        lid_up, manual_on, running, lid_rev, drop_manual;
    logic [9:0]  reps_left;
    logic [2:0]  phase;
    logic [7:0]  hold_cnt;
    logic [3:0]  coils;
    logic [23:0] last_echo;

    plc_in_t  beat_q [$];
    plc_out_t lid_status_q [$];
    int  errors = 0;
    int  beats_queued = 0;
    int  beats_taken = 0;
    int  status_checked = 0;
    int  moves_seen = 0;
    int  settings_used = 0;
    bit  calm = 1'b0;
    int unsigned cycle_cnt = 0;

    function automatic logic [3:0] coil_for(logic [2:0] ph, logic rev);
        return COIL_SEQ[rev ? ~ph : ph];
    endfunction

    // Launch an open or close motion; returns 1 when it completes at once.
    function automatic logic start_move(logic opening);
        logic [9:0] reps;
        reps = opening ? cfg_m.open_cycles : cfg_m.close_cycles;
        lid_up = opening;
        lid_rev = !opening;
        if (reps == 10'd0)
        begin
            if (drop_manual)
                manual_on = 1'b0;
            drop_manual = 1'b0;
            return 1'b1;
        end
        running = 1'b1;
        reps_left = reps;
        phase = 3'd0;
        hold_cnt = 8'd0;
        coils = coil_for(3'd0, lid_rev);
        return 1'b0;
    endfunction

    // Advance the predicted controller by one input beat and return its status.
    function automatic plc_out_t step_lid(plc_in_t beat);
        plc_out_t    res;
        logic        finished;
        logic [ECHO_W:0] raw;
        logic [23:0] cnt;
        finished = 1'b0;
        case (beat.opcode)
            OP_TICK:
            begin
                if (running)
                begin
                    hold_cnt = hold_cnt + 8'd1;
                    if (hold_cnt >= cfg_m.step_ticks)
                    begin
                        hold_cnt = 8'd0;
                        phase = phase + 3'd1;
                        if (phase == 3'd0)
                        begin
                            reps_left = reps_left - 10'd1;
                            if (reps_left == 10'd0)
                            begin
                                running = 1'b0;
                                finished = 1'b1;
                                if (drop_manual)
                                    manual_on = 1'b0;
                                drop_manual = 1'b0;
                            end
                        end
                        if (running)
                            coils = coil_for(phase, lid_rev);
                    end
                end
            end
            OP_MEASURE:
            begin
                if (!running)
                begin
                    raw = {1'b0, beat.overflow_count, beat.capture_value};
                    cnt = (raw > ECHO_MAX) ? ECHO_MAX[23:0] : raw[23:0];
                    last_echo = cnt;
                    if (cnt <= cfg_m.valid_limit_count)
                    begin
                        if (!manual_on)
                        begin
                            if (!lid_up && cnt <= cfg_m.near_count)
                                finished = start_move(1'b1);
                            else if (lid_up && cnt > cfg_m.near_count)
                                finished = start_move(1'b0);
                        end
                        else
                        begin
                            if (lid_up && cnt <= cfg_m.manual_close_count)
                            begin
                                drop_manual = 1'b1;
                                finished = start_move(1'b0);
                            end
                            else if (!lid_up)
                                finished = start_move(1'b1);
                        end
                    end
                end
            end
            OP_BUTTON:
                manual_on = 1'b1;
            default:
                ;
        endcase
        res.coil_pattern = coils;
        res.lid_open     = lid_up;
        res.manual_mode  = manual_on;
        res.moving       = running;
        res.move_done    = finished;
        res.echo_count   = last_echo;
        return res;
    endfunction

    // Idle lengths: mostly short, now and then long.
    function automatic int pause_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // Input side: present queued beats with random gaps between them.
    always @(posedge clk)
    begin : driver
        int gap_left;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                lid_status_q.push_back(step_lid(item_data));
                beats_taken++;
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left != 0)
                begin
                    item_valid <= 1'b0;
                    gap_left = gap_left - 1;
                end
                else if (beat_q.size() != 0)
                begin
                    item_valid <= 1'b1;
                    item_data <= beat_q.pop_front();
                    gap_left = (calm || $urandom_range(0, 99) < 60) ? 0 : pause_len();
                end
                else
                    item_valid <= 1'b0;
            end
        end
        else
            gap_left = 0;
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result side: random stalls, and each accepted beat checked against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        int stall_left;
        plc_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (lid_status_q.size() == 0)
            begin
                $error("result beat with no prediction pending");
                errors++;
            end
            else
            begin
                want = lid_status_q.pop_front();
                check_field("coil_pattern", want.coil_pattern, result_data.coil_pattern);
                check_field("lid_open", want.lid_open, result_data.lid_open);
                check_field("manual_mode", want.manual_mode, result_data.manual_mode);
                check_field("moving", want.moving, result_data.moving);
                check_field("move_done", want.move_done, result_data.move_done);
                check_field("echo_count", want.echo_count, result_data.echo_count);
                status_checked++;
                if (want.move_done)
                    moves_seen++;
            end
        end
        if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (rst_n && !calm && $urandom_range(0, 99) < 25)
        begin
            result_stall <= 1'b1;
            stall_left = pause_len() - 1;
        end
        else
            result_stall <= 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_beat(logic [1:0] op, logic [23:0] payload);
        plc_in_t b;
        b.opcode = op;
        b.capture_value = payload[15:0];
        b.overflow_count = payload[23:16];
        beat_q.push_back(b);
        beats_queued++;
    endtask

    // Echo counts aimed at the thresholds, the extremes and random points.
    function automatic logic [23:0] pick_echo();
        case ($urandom_range(0, 9))
            0: return cfg_m.near_count;
            1: return cfg_m.near_count + 24'd1;
            2: return cfg_m.manual_close_count;
            3: return cfg_m.manual_close_count + 24'd1;
            4: return cfg_m.valid_limit_count;
            5: return cfg_m.valid_limit_count + 24'd1;
            6: return 24'd0;
            7: return 24'hFFFFFF;
            8: return 24'($urandom_range(0, cfg_m.near_count));
            default: return 24'($urandom());
        endcase
    endfunction

    // One measurement followed by a run of ticks long enough to finish a short motion,
    // sometimes cut short or broken up, sometimes a lone noise beat. A run never
    // has more ticks than one phase has beats, so long motions carry over into later phases.
    task automatic add_episode();
        int r;
        int run_len;
        int n;
        int reps;
        int hold;
        reps = (cfg_m.open_cycles > cfg_m.close_cycles) ? cfg_m.open_cycles : cfg_m.close_cycles;
        hold = (cfg_m.step_ticks == 8'd0) ? 1 : cfg_m.step_ticks;
        run_len = 8 * reps * hold;
        r = $urandom_range(0, 99);
        if (r < 10)
            add_beat(2'($urandom_range(0, 3)), 24'($urandom()));
        else
        begin
            if ($urandom_range(0, 4) == 0)
                add_beat(OP_BUTTON, 24'($urandom()));
            add_beat(OP_MEASURE, pick_echo());
            n = (r < 75) ? run_len + $urandom_range(0, 3) : $urandom_range(0, run_len);
            if (n > PHASE_BEATS)
                n = PHASE_BEATS;
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 49) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        add_beat(OP_BUTTON, 24'($urandom()));
                    else
                        add_beat(OP_MEASURE, pick_echo());
                end
                add_beat(OP_TICK, 24'($urandom()));
            end
        end
    endtask

    task automatic set_reg(plc_reg_t idx, logic [23:0] val);
        case (idx)
            REG_NEAR_COUNT:         cfg_m.near_count = val;
            REG_MANUAL_CLOSE_COUNT: cfg_m.manual_close_count = val;
            REG_VALID_LIMIT_COUNT:  cfg_m.valid_limit_count = val;
            REG_OPEN_CYCLES:        cfg_m.open_cycles = val[CYCLE_W-1:0];
            REG_CLOSE_CYCLES:       cfg_m.close_cycles = val[CYCLE_W-1:0];
            REG_STEP_TICKS:         cfg_m.step_ticks = val[TICK_W-1:0];
            default:                ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_settings(logic [23:0] near, logic [23:0] mclose, logic [23:0] limit,
                                 logic [23:0] openc, logic [23:0] closec, logic [23:0] steps);
        set_reg(REG_NEAR_COUNT, near);
        set_reg(REG_MANUAL_CLOSE_COUNT, mclose);
        set_reg(REG_VALID_LIMIT_COUNT, limit);
        set_reg(REG_OPEN_CYCLES, openc);
        set_reg(REG_CLOSE_CYCLES, closec);
        set_reg(REG_STEP_TICKS, steps);
        settings_used++;
    endtask

    // Wait until every queued beat is taken and every predicted status has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (beat_q.size() != 0 || item_valid || lid_status_q.size() != 0);
    endtask

    initial
    begin
        int start;
        logic [23:0] near, mclose, limit, openc, closec, steps;

        // Predicted state after reset.
        cfg_m.near_count         = NEAR_COUNT_RST;
        cfg_m.manual_close_count = MANUAL_CLOSE_COUNT_RST;
        cfg_m.valid_limit_count  = VALID_LIMIT_COUNT_RST;
        cfg_m.open_cycles        = OPEN_CYCLES_RST;
        cfg_m.close_cycles       = CLOSE_CYCLES_RST;
        cfg_m.step_ticks         = STEP_TICKS_RST;
        lid_up = 1'b0;
        manual_on = 1'b0;
        running = 1'b0;
        lid_rev = 1'b0;
        drop_manual = 1'b0;
        reps_left = '0;
        phase = '0;
        hold_cnt = '0;
        coils = '0;
        last_echo = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Decisions with zero-length motions: invalid counts, auto open and close,
        // manual open, manual close that leaves manual mode, ignored opcode.
        load_settings(NEAR_COUNT_RST, MANUAL_CLOSE_COUNT_RST, VALID_LIMIT_COUNT_RST, 0, 0, 1);
        add_beat(OP_SPARE, 24'hFFFFFF);
        add_beat(OP_MEASURE, 24'hFFFFFF);
        add_beat(OP_MEASURE, 24'd58309);
        add_beat(OP_MEASURE, 24'd0);
        add_beat(OP_MEASURE, 24'd874);
        add_beat(OP_MEASURE, 24'd875);
        add_beat(OP_BUTTON, 24'd0);
        add_beat(OP_MEASURE, 24'd58308);
        add_beat(OP_MEASURE, 24'd1342);
        add_beat(OP_MEASURE, 24'd1341);
        drain();

        // Real motions with a zero hold: measurement and button during motion,
        // then a manual close that clears manual mode when it ends.
        load_settings(NEAR_COUNT_RST, MANUAL_CLOSE_COUNT_RST, VALID_LIMIT_COUNT_RST, 1, 1, 0);
        add_beat(OP_MEASURE, 24'd874);
        add_beat(OP_MEASURE, 24'd0);
        add_beat(OP_BUTTON, 24'hFFFFFF);
        repeat (8) add_beat(OP_TICK, 24'hFFFFFF);
        add_beat(OP_MEASURE, 24'd1341);
        repeat (8) add_beat(OP_TICK, 24'd0);
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 7; ph++)
        begin
            calm = (ph == 2);
            near   = 24'($urandom_range(0, 3000));
            mclose = 24'($urandom_range(0, 4000));
            limit  = 24'($urandom_range(0, 70000));
            openc  = 24'($urandom_range(1, 3));
            closec = 24'($urandom_range(1, 3));
            steps  = 24'($urandom_range(1, 3));
            case (ph)
                0:
                begin
                    near = 24'd0;
                    mclose = 24'd0;
                    limit = 24'd0;
                    steps = 24'd0;
                end
                1:
                begin
                    near = 24'hFFFFFF;
                    mclose = 24'hFFFFFF;
                    limit = 24'hFFFFFF;
                end
                3:
                begin
                    openc = 24'd9;
                    closec = 24'd0;
                    steps = 24'd1;
                end
                4:
                begin
                    openc = 24'd0;
                    closec = 24'd1;
                    steps = 24'd255;
                end
                default:
                    ;
            endcase
            load_settings(near, mclose, limit, openc, closec, steps);
            start = beats_queued;
            while (beats_queued - start < PHASE_BEATS)
                add_episode();
            drain();
        end

        repeat (6) @(posedge clk);
        if (lid_status_q.size() != 0)
        begin
            $error("%0d predicted status beats never arrived", lid_status_q.size());
            errors++;
        end
        $display("Drove %0d input beats under %0d register settings.", beats_taken, settings_used);
        $display("Checked %0d status beats, %0d of them ending a motion.",
                 status_checked, moves_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== proximity_lid_stepper_controller.f =====
sv/plc_pkg.sv
sv/plc_core.sv
sv/proximity_lid_stepper_controller.sv
verif/tb.sv
